// ===== src/assert_macros.svh =====
// assertion macros shared by the blit engine modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define CRFB_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// condition must never be seen outside reset
`define CRFB_NEVER(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

// ===== src/crfb_pkg.sv =====
// shared types, codes and widths of the clipped rectangle fill and blit engine
package crfb_pkg;

   localparam int ADDR_BITS      = 48;
   localparam int COORD_BITS     = 16;
   localparam int COLOR_BITS     = 32;
   localparam int SEQ_BITS       = 32;
   localparam int CSR_INDEX_BITS = 3;
   localparam int OFF_BITS       = 2 * COORD_BITS + 1;

   localparam logic OP_CMD  = 1'b0;
   localparam logic OP_STEP = 1'b1;

   localparam logic [1:0] KIND_FILL = 2'd0;
   localparam logic [1:0] KIND_BLIT = 2'd1;
   localparam logic [1:0] KIND_FLIP = 2'd2;
   localparam logic [1:0] KIND_BAD  = 2'd3;

   localparam logic [1:0] ACC_NONE = 2'd0;
   localparam logic [1:0] ACC_FILL = 2'd1;
   localparam logic [1:0] ACC_COPY = 2'd2;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NOT_READY = 3'd1;
   localparam logic [2:0] ST_BAD_KIND  = 3'd2;
   localparam logic [2:0] ST_BUSY      = 3'd3;
   localparam logic [2:0] ST_IDLE_STEP = 3'd4;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FB_BASE   = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FB_WIDTH  = CSR_INDEX_BITS'(1);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FB_HEIGHT = CSR_INDEX_BITS'(2);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FB_STRIDE = CSR_INDEX_BITS'(3);

   typedef struct packed {
      logic                  opcode;
      logic [1:0]            kind;
      logic [COORD_BITS-1:0] rect_x;
      logic [COORD_BITS-1:0] rect_y;
      logic [COORD_BITS-1:0] rect_w;
      logic [COORD_BITS-1:0] rect_h;
      logic [COLOR_BITS-1:0] fill_color;
      logic [ADDR_BITS-1:0]  dest_addr;
      logic [ADDR_BITS-1:0]  source_addr;
      logic [COORD_BITS-1:0] pitch;
   } req_type;

   typedef struct packed {
      logic [1:0]            access_kind;
      logic [ADDR_BITS-1:0]  write_addr;
      logic [ADDR_BITS-1:0]  read_addr;
      logic [COLOR_BITS-1:0] write_data;
      logic                  last;
      logic [2:0]            status;
      logic [SEQ_BITS-1:0]   sequence_res;
   } rsp_type;

   typedef struct packed {
      logic                      en;
      logic [CSR_INDEX_BITS-1:0] index;
      logic [ADDR_BITS-1:0]      data;
   } csr_wr_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0]  fb_base;
      logic [COORD_BITS-1:0] fb_width;
      logic [COORD_BITS-1:0] fb_height;
      logic [COORD_BITS-1:0] fb_stride;
   } cfg_type;

   typedef struct packed {
      logic                  ready;
      logic                  go;
      logic                  flip_load;
      logic [COORD_BITS-1:0] clip_w;
      logic [COORD_BITS-1:0] clip_h;
      logic [COORD_BITS-1:0] dst_pitch;
      logic [ADDR_BITS-1:0]  dst_start;
   } clip_type;

endpackage

// ===== src/clipped_rect_fill_blit_engine_top.sv =====
// top level: input and result registers around the blit engine core
// Takes one item per clock unless the result side stalls and returns exactly
// one result per item. A command item is checked and clipped; one that passes
// the busy, ready and kind checks gets a nonzero 32-bit sequence number. Each
// step item after an accepted fill or blit yields one pixel access in
// row-major order, with last set on the final pixel. The pixel walk keeps
// running row addresses and adds one column offset per step, so steps issue
// back to back at one per clock unless stalled. The input register and the
// rsp_ result register each hold one transfer, so both sides may stall freely.
// Framebuffer registers are written through csr_ and must only change while
// no command is walking and no result is outstanding.
module clipped_rect_fill_blit_engine_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_opcode,
   input  logic [1:0]                          req_kind,
   input  logic [crfb_pkg::COORD_BITS-1:0]     req_rect_x,
   input  logic [crfb_pkg::COORD_BITS-1:0]     req_rect_y,
   input  logic [crfb_pkg::COORD_BITS-1:0]     req_rect_w,
   input  logic [crfb_pkg::COORD_BITS-1:0]     req_rect_h,
   input  logic [crfb_pkg::COLOR_BITS-1:0]     req_fill_color,
   input  logic [crfb_pkg::ADDR_BITS-1:0]      req_dest_addr,
   input  logic [crfb_pkg::ADDR_BITS-1:0]      req_source_addr,
   input  logic [crfb_pkg::COORD_BITS-1:0]     req_pitch,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_access_kind,
   output logic [crfb_pkg::ADDR_BITS-1:0]      rsp_write_addr,
   output logic [crfb_pkg::ADDR_BITS-1:0]      rsp_read_addr,
   output logic [crfb_pkg::COLOR_BITS-1:0]     rsp_write_data,
   output logic                                rsp_last,
   output logic [2:0]                          rsp_status,
   output logic [crfb_pkg::SEQ_BITS-1:0]       rsp_sequence_res,
   input  logic                                csr_we,
   input  logic [crfb_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [crfb_pkg::ADDR_BITS-1:0]      csr_wdata
);

   crfb_pkg::req_type    in_ff;
   crfb_pkg::req_type    req_in;
   crfb_pkg::rsp_type    rsp_ff;
   crfb_pkg::rsp_type    rsp_in;
   crfb_pkg::csr_wr_type csr;
   logic                 in_valid_ff, in_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 out_free;
   logic                 proc_fire;
   logic                 req_take;

   assign req_in = '{opcode: req_opcode, kind: req_kind, rect_x: req_rect_x,
                     rect_y: req_rect_y, rect_w: req_rect_w, rect_h: req_rect_h,
                     fill_color: req_fill_color, dest_addr: req_dest_addr,
                     source_addr: req_source_addr, pitch: req_pitch};
   assign csr    = '{en: csr_we, index: csr_index, data: csr_wdata};

   // the result register frees up in the same cycle its transfer completes
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign proc_fire = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !proc_fire);
   assign rsp_valid_in = proc_fire || (rsp_valid_ff && rsp_stall);

   crfb_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr),
      .proc_fire (proc_fire),
      .req       (in_ff),
      .rsp       (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ff <= req_in;
      end
      if (proc_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_access_kind  = rsp_ff.access_kind;
   assign rsp_write_addr   = rsp_ff.write_addr;
   assign rsp_read_addr    = rsp_ff.read_addr;
   assign rsp_write_data   = rsp_ff.write_data;
   assign rsp_last         = rsp_ff.last;
   assign rsp_status       = rsp_ff.status;
   assign rsp_sequence_res = rsp_ff.sequence_res;

`include "assert_macros.svh"

   `CRFB_ASSERT(a_take_fills_stage, clock, reset, req_take |=> in_valid_ff, "accepted transfer not held in input stage")
   `CRFB_ASSERT(a_fire_fills_result, clock, reset, proc_fire |=> rsp_valid_ff, "processed item produced no result")

endmodule

// ===== src/crfb_clip.sv =====
// command check, clipping and start address of the first destination row
module crfb_clip (
   input  crfb_pkg::cfg_type  cfg,
   input  logic [crfb_pkg::ADDR_BITS-1:0] active_base,
   input  crfb_pkg::req_type  req,
   output crfb_pkg::clip_type clip
);

   logic [crfb_pkg::COORD_BITS-1:0]   dp;
   logic [crfb_pkg::ADDR_BITS-1:0]    dst;
   logic [crfb_pkg::COORD_BITS-1:0]   room_w;
   logic [crfb_pkg::COORD_BITS-1:0]   room_h;
   logic [crfb_pkg::COORD_BITS-1:0]   cw;
   logic [crfb_pkg::COORD_BITS-1:0]   ch;
   logic [2*crfb_pkg::COORD_BITS-1:0] prod;
   logic [crfb_pkg::OFF_BITS-1:0]     pix_off;
   logic                              base_ok;
   logic                              src_ok;
   logic                              in_range;

   always_comb begin
      dp  = (req.pitch != '0) ? req.pitch : cfg.fb_stride;
      dst = (req.dest_addr != '0) ? req.dest_addr : active_base;

      clip.ready = (cfg.fb_base != '0) && (cfg.fb_width != '0) &&
                   (cfg.fb_height != '0) && (cfg.fb_stride >= cfg.fb_width);

      base_ok  = (dp >= cfg.fb_width) && (dst != '0);
      src_ok   = (req.kind != crfb_pkg::KIND_BLIT) ||
                 ((req.source_addr != '0) && (req.pitch != '0));
      in_range = (req.rect_x < cfg.fb_width) && (req.rect_y < cfg.fb_height);

      // only meaningful when the origin lies inside the framebuffer
      room_w = cfg.fb_width - req.rect_x;
      room_h = cfg.fb_height - req.rect_y;
      cw     = (req.rect_w < room_w) ? req.rect_w : room_w;
      ch     = (req.rect_h < room_h) ? req.rect_h : room_h;

      clip.flip_load = base_ok && (req.kind == crfb_pkg::KIND_FLIP) &&
                       (req.dest_addr != '0);
      clip.go        = base_ok && (req.kind != crfb_pkg::KIND_FLIP) &&
                       (req.kind != crfb_pkg::KIND_BAD) && src_ok && in_range &&
                       (cw != '0) && (ch != '0);

      prod    = req.rect_y * dp;
      pix_off = {1'b0, prod} + {{(crfb_pkg::COORD_BITS + 1){1'b0}}, req.rect_x};

      clip.clip_w    = cw;
      clip.clip_h    = ch;
      clip.dst_pitch = dp;
      clip.dst_start = dst + crfb_pkg::ADDR_BITS'({pix_off, 2'b00});
   end

endmodule

// ===== src/crfb_core.sv =====
// framebuffer registers, command state, pixel walk and result build
module crfb_core (
   input  logic                  clock,
   input  logic                  reset,
   input  crfb_pkg::csr_wr_type  csr,
   input  logic                  proc_fire,
   input  crfb_pkg::req_type     req,
   output crfb_pkg::rsp_type     rsp
);

   crfb_pkg::cfg_type                 cfg_ff;
   crfb_pkg::clip_type                clip;
   logic [crfb_pkg::ADDR_BITS-1:0]    active_base_ff, active_base_in;
   logic                              busy_ff, busy_in;
   logic                              copy_mode_ff, copy_mode_in;
   logic [crfb_pkg::COORD_BITS-1:0]   col_count_ff, col_count_in;
   logic [crfb_pkg::COORD_BITS-1:0]   row_count_ff, row_count_in;
   logic [crfb_pkg::COORD_BITS-1:0]   clip_w_ff, clip_w_in;
   logic [crfb_pkg::COORD_BITS-1:0]   clip_h_ff, clip_h_in;
   logic [crfb_pkg::COLOR_BITS-1:0]   color_latch_ff, color_latch_in;
   logic [crfb_pkg::ADDR_BITS-1:0]    row_dst_ff, row_dst_in;
   logic [crfb_pkg::ADDR_BITS-1:0]    row_src_ff, row_src_in;
   logic [crfb_pkg::COORD_BITS-1:0]   dst_pitch_ff, dst_pitch_in;
   logic [crfb_pkg::COORD_BITS-1:0]   src_pitch_ff, src_pitch_in;
   logic [crfb_pkg::SEQ_BITS-1:0]     seq_next_ff, seq_next_in;
   logic [crfb_pkg::SEQ_BITS-1:0]     seq_current_ff, seq_current_in;
   logic [crfb_pkg::SEQ_BITS-1:0]     seq_inc;
   logic [crfb_pkg::ADDR_BITS-1:0]    col_off;
   logic                              row_end;
   logic                              cmd_end;

   crfb_clip u_clip (
      .cfg         (cfg_ff),
      .active_base (active_base_ff),
      .req         (req),
      .clip        (clip)
   );

   always_comb begin
      active_base_in = active_base_ff;
      busy_in        = busy_ff;
      copy_mode_in   = copy_mode_ff;
      col_count_in   = col_count_ff;
      row_count_in   = row_count_ff;
      clip_w_in      = clip_w_ff;
      clip_h_in      = clip_h_ff;
      color_latch_in = color_latch_ff;
      row_dst_in     = row_dst_ff;
      row_src_in     = row_src_ff;
      dst_pitch_in   = dst_pitch_ff;
      src_pitch_in   = src_pitch_ff;
      seq_next_in    = seq_next_ff;
      seq_current_in = seq_current_ff;
      rsp            = '0;

      col_off = crfb_pkg::ADDR_BITS'({col_count_ff, 2'b00});
      row_end = (col_count_ff + 1'b1) == clip_w_ff;
      cmd_end = row_end && ((row_count_ff + 1'b1) == clip_h_ff);

      // sequence wraps past the all-ones value straight to one
      seq_inc = seq_next_ff + 1'b1;
      if (seq_inc == '0) begin
         seq_inc = crfb_pkg::SEQ_BITS'(1);
      end

      case (req.opcode)
         crfb_pkg::OP_STEP: begin
            if (!busy_ff) begin
               rsp.status = crfb_pkg::ST_IDLE_STEP;
            end else begin
               rsp.status       = crfb_pkg::ST_OK;
               rsp.sequence_res = seq_current_ff;
               rsp.write_addr   = row_dst_ff + col_off;
               if (copy_mode_ff) begin
                  rsp.access_kind = crfb_pkg::ACC_COPY;
                  rsp.read_addr   = row_src_ff + col_off;
               end else begin
                  rsp.access_kind = crfb_pkg::ACC_FILL;
                  rsp.write_data  = color_latch_ff;
               end
               if (!row_end) begin
                  col_count_in = col_count_ff + 1'b1;
               end else if (cmd_end) begin
                  rsp.last     = 1'b1;
                  busy_in      = 1'b0;
                  col_count_in = '0;
                  row_count_in = '0;
               end else begin
                  col_count_in = '0;
                  row_count_in = row_count_ff + 1'b1;
                  row_dst_in   = row_dst_ff +
                                 crfb_pkg::ADDR_BITS'({dst_pitch_ff, 2'b00});
                  row_src_in   = row_src_ff +
                                 crfb_pkg::ADDR_BITS'({src_pitch_ff, 2'b00});
               end
            end
         end
         default: begin
            rsp.last = 1'b1;
            if (busy_ff) begin
               rsp.status = crfb_pkg::ST_BUSY;
            end else if (!clip.ready) begin
               rsp.status = crfb_pkg::ST_NOT_READY;
            end else if (req.kind == crfb_pkg::KIND_BAD) begin
               rsp.status = crfb_pkg::ST_BAD_KIND;
            end else begin
               rsp.status       = crfb_pkg::ST_OK;
               rsp.sequence_res = seq_next_ff;
               seq_current_in   = seq_next_ff;
               seq_next_in      = seq_inc;
               if (clip.flip_load) begin
                  active_base_in = req.dest_addr;
               end
               if (clip.go) begin
                  rsp.last       = 1'b0;
                  busy_in        = 1'b1;
                  copy_mode_in   = (req.kind == crfb_pkg::KIND_BLIT);
                  col_count_in   = '0;
                  row_count_in   = '0;
                  clip_w_in      = clip.clip_w;
                  clip_h_in      = clip.clip_h;
                  color_latch_in = req.fill_color;
                  row_dst_in     = clip.dst_start;
                  row_src_in     = req.source_addr;
                  dst_pitch_in   = clip.dst_pitch;
                  src_pitch_in   = req.pitch;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff         <= '0;
         active_base_ff <= '0;
         busy_ff        <= 1'b0;
         copy_mode_ff   <= 1'b0;
         col_count_ff   <= '0;
         row_count_ff   <= '0;
         seq_next_ff    <= crfb_pkg::SEQ_BITS'(1);
         seq_current_ff <= '0;
      end else begin
         if (csr.en) begin
            unique case (csr.index)
               crfb_pkg::CSR_FB_BASE:   cfg_ff.fb_base <= csr.data;
               crfb_pkg::CSR_FB_WIDTH:
                  cfg_ff.fb_width <= csr.data[crfb_pkg::COORD_BITS-1:0];
               crfb_pkg::CSR_FB_HEIGHT:
                  cfg_ff.fb_height <= csr.data[crfb_pkg::COORD_BITS-1:0];
               crfb_pkg::CSR_FB_STRIDE:
                  cfg_ff.fb_stride <= csr.data[crfb_pkg::COORD_BITS-1:0];
               default: ;
            endcase
         end
         // a base write also moves the displayed frame
         if (csr.en && (csr.index == crfb_pkg::CSR_FB_BASE)) begin
            active_base_ff <= csr.data;
         end else if (proc_fire) begin
            active_base_ff <= active_base_in;
         end
         if (proc_fire) begin
            busy_ff        <= busy_in;
            copy_mode_ff   <= copy_mode_in;
            col_count_ff   <= col_count_in;
            row_count_ff   <= row_count_in;
            seq_next_ff    <= seq_next_in;
            seq_current_ff <= seq_current_in;
         end
      end
   end

   // latched command payload, only read while busy
   always_ff @(posedge clock) begin
      if (proc_fire) begin
         clip_w_ff      <= clip_w_in;
         clip_h_ff      <= clip_h_in;
         color_latch_ff <= color_latch_in;
         row_dst_ff     <= row_dst_in;
         row_src_ff     <= row_src_in;
         dst_pitch_ff   <= dst_pitch_in;
         src_pitch_ff   <= src_pitch_in;
      end
   end

`include "assert_macros.svh"

   `CRFB_NEVER(a_seq_never_zero, clock, reset, seq_next_ff == '0, "sequence counter hit zero")
   `CRFB_ASSERT(a_walk_in_rect, clock, reset, busy_ff |-> (col_count_ff < clip_w_ff) && (row_count_ff < clip_h_ff), "walk left the clipped rectangle")
   `CRFB_ASSERT(a_last_access_ends, clock, reset, proc_fire && rsp.last && (rsp.access_kind != crfb_pkg::ACC_NONE) |=> !busy_ff, "engine still busy after last access")
   `CRFB_ASSERT(a_start_sets_busy, clock, reset, proc_fire && (req.opcode == crfb_pkg::OP_CMD) && !busy_ff && !rsp.last |=> busy_ff, "accepted command did not start the walk")

endmodule

// ===== tb/tb.sv =====
// testbench for the clipped rectangle fill and blit engine: directed and random pixel walks
module tb;
   import crfb_pkg::*;

   localparam int CYCLE_LIMIT = 500000;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic                      req_opcode;
   logic [1:0]                req_kind;
   logic [COORD_BITS-1:0]     req_rect_x;
   logic [COORD_BITS-1:0]     req_rect_y;
   logic [COORD_BITS-1:0]     req_rect_w;
   logic [COORD_BITS-1:0]     req_rect_h;
   logic [COLOR_BITS-1:0]     req_fill_color;
   logic [ADDR_BITS-1:0]      req_dest_addr;
   logic [ADDR_BITS-1:0]      req_source_addr;
   logic [COORD_BITS-1:0]     req_pitch;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [1:0]                rsp_access_kind;
   logic [ADDR_BITS-1:0]      rsp_write_addr;
   logic [ADDR_BITS-1:0]      rsp_read_addr;
   logic [COLOR_BITS-1:0]     rsp_write_data;
   logic                      rsp_last;
   logic [2:0]                rsp_status;
   logic [SEQ_BITS-1:0]       rsp_sequence_res;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [ADDR_BITS-1:0]      csr_wdata;

   clipped_rect_fill_blit_engine_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_kind         (req_kind),
      .req_rect_x       (req_rect_x),
      .req_rect_y       (req_rect_y),
      .req_rect_w       (req_rect_w),
      .req_rect_h       (req_rect_h),
      .req_fill_color   (req_fill_color),
      .req_dest_addr    (req_dest_addr),
      .req_source_addr  (req_source_addr),
      .req_pitch        (req_pitch),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_access_kind  (rsp_access_kind),
      .rsp_write_addr   (rsp_write_addr),
      .rsp_read_addr    (rsp_read_addr),
      .rsp_write_data   (rsp_write_data),
      .rsp_last         (rsp_last),
      .rsp_status       (rsp_status),
      .rsp_sequence_res (rsp_sequence_res),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // framebuffer registers as the engine sees them
   logic [ADDR_BITS-1:0]  cfg_base;
   logic [COORD_BITS-1:0] cfg_width, cfg_height, cfg_stride;

   // engine state mirrored for prediction
   logic [ADDR_BITS-1:0]  act_base;
   bit                    walk_busy, walk_copy;
   logic [COORD_BITS-1:0] walk_col, walk_row, walk_w, walk_h, walk_x, walk_y;
   logic [COLOR_BITS-1:0] walk_color;
   logic [ADDR_BITS-1:0]  walk_dst, walk_src;
   logic [COORD_BITS-1:0] walk_dpitch, walk_spitch;
   logic [SEQ_BITS-1:0]   seq_next_num, seq_active;

   rsp_type access_q[$];
   rsp_type want_rsp;
   int      errors = 0;
   int      items_sent = 0;
   int      cycle_count = 0;
   int      burst_left = 0;
   int      hold_left = 0;
   int      stall_run = 0;
   int      stall_pct = 0;
   bit      hold_req = 1'b0;

   function automatic logic [ADDR_BITS-1:0] rand48();
      return {16'($urandom), 32'($urandom)};
   endfunction

   // works out the result of one transfer and advances the mirrored state
   function automatic rsp_type predict_access(req_type r);
      rsp_type               o;
      logic [63:0]           pix;
      logic [COORD_BITS-1:0] dp, cw, ch;
      logic [ADDR_BITS-1:0]  dst;
      bit                    go;
      o = '0;
      if (r.opcode == OP_STEP) begin
         if (!walk_busy) begin
            o.status = ST_IDLE_STEP;
            return o;
         end
         pix = (64'(walk_y) + 64'(walk_row)) * 64'(walk_dpitch) + 64'(walk_x) + 64'(walk_col);
         o.write_addr = walk_dst + 48'(pix << 2);
         if (walk_copy) begin
            pix = 64'(walk_row) * 64'(walk_spitch) + 64'(walk_col);
            o.access_kind = ACC_COPY;
            o.read_addr = walk_src + 48'(pix << 2);
         end else begin
            o.access_kind = ACC_FILL;
            o.write_data = walk_color;
         end
         walk_col++;
         if (walk_col >= walk_w) begin
            walk_col = '0;
            walk_row++;
            if (walk_row >= walk_h) begin
               o.last = 1'b1;
               walk_busy = 1'b0;
               walk_row = '0;
            end
         end
         o.status = ST_OK;
         o.sequence_res = seq_active;
         return o;
      end
      o.last = 1'b1;
      if (walk_busy) begin
         o.status = ST_BUSY;
         return o;
      end
      if (cfg_base == 0 || cfg_width == 0 || cfg_height == 0 || cfg_stride < cfg_width) begin
         o.status = ST_NOT_READY;
         return o;
      end
      if (r.kind == KIND_BAD) begin
         o.status = ST_BAD_KIND;
         return o;
      end
      seq_active = seq_next_num;
      seq_next_num++;
      if (seq_next_num == 0) seq_next_num = 1;
      o.status = ST_OK;
      o.sequence_res = seq_active;
      dp = (r.pitch != 0) ? r.pitch : cfg_stride;
      dst = (r.dest_addr != 0) ? r.dest_addr : act_base;
      go = !(dp < cfg_width || dst == 0);
      if (go && r.kind == KIND_FLIP) begin
         if (r.dest_addr != 0) act_base = r.dest_addr;
         go = 1'b0;
      end
      if (go && r.kind == KIND_BLIT && (r.source_addr == 0 || r.pitch == 0)) go = 1'b0;
      if (go && (r.rect_x >= cfg_width || r.rect_y >= cfg_height)) go = 1'b0;
      if (go) begin
         cw = (r.rect_w < cfg_width - r.rect_x) ? r.rect_w : cfg_width - r.rect_x;
         ch = (r.rect_h < cfg_height - r.rect_y) ? r.rect_h : cfg_height - r.rect_y;
         if (cw == 0 || ch == 0) go = 1'b0;
      end
      if (!go) return o;
      walk_busy = 1'b1;
      walk_copy = (r.kind == KIND_BLIT);
      walk_col = '0;
      walk_row = '0;
      walk_w = cw;
      walk_h = ch;
      walk_x = r.rect_x;
      walk_y = r.rect_y;
      walk_color = r.fill_color;
      walk_dst = dst;
      walk_src = r.source_addr;
      walk_dpitch = dp;
      walk_spitch = r.pitch;
      o.last = 1'b0;
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      if (errors <= 40)
         $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want,
                  cycle_count);
   endtask

   // result side: one transfer is compared with the oldest expected access
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (access_q.size() == 0) begin
            report_mismatch("unexpected result, status", 64'(rsp_status), 64'd0);
         end else begin
            want_rsp = access_q.pop_front();
            if (rsp_access_kind !== want_rsp.access_kind)
               report_mismatch("access_kind", 64'(rsp_access_kind),
                               64'(want_rsp.access_kind));
            if (rsp_write_addr !== want_rsp.write_addr)
               report_mismatch("write_addr", 64'(rsp_write_addr),
                               64'(want_rsp.write_addr));
            if (rsp_read_addr !== want_rsp.read_addr)
               report_mismatch("read_addr", 64'(rsp_read_addr), 64'(want_rsp.read_addr));
            if (rsp_write_data !== want_rsp.write_data)
               report_mismatch("write_data", 64'(rsp_write_data),
                               64'(want_rsp.write_data));
            if (rsp_last !== want_rsp.last)
               report_mismatch("last", 64'(rsp_last), 64'(want_rsp.last));
            if (rsp_status !== want_rsp.status)
               report_mismatch("status", 64'(rsp_status), 64'(want_rsp.status));
            if (rsp_sequence_res !== want_rsp.sequence_res)
               report_mismatch("sequence_res", 64'(rsp_sequence_res),
                               64'(want_rsp.sequence_res));
         end
      end
   end

   // receiver stall pattern, with a long hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_req) begin
            hold_left = 300;
            hold_req = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            if (stall_run == 0) begin
               stall_run = $urandom_range(1, 32);
               case ($urandom_range(0, 4))
                  0, 1: stall_pct = 0;
                  2: stall_pct = 20;
                  3: stall_pct = 50;
                  default: stall_pct = 85;
               endcase
            end
            stall_run--;
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // offers one item in the current burst and waits for its transfer
   task automatic send_item(req_type r);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 7) : 0;
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_opcode      <= r.opcode;
      req_kind        <= r.kind;
      req_rect_x      <= r.rect_x;
      req_rect_y      <= r.rect_y;
      req_rect_w      <= r.rect_w;
      req_rect_h      <= r.rect_h;
      req_fill_color  <= r.fill_color;
      req_dest_addr   <= r.dest_addr;
      req_source_addr <= r.source_addr;
      req_pitch       <= r.pitch;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      access_q.push_back(predict_access(r));
      items_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (access_q.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [ADDR_BITS-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // width, height and stride registers get junk above bit 15, which the engine must drop
   task automatic set_fb(logic [ADDR_BITS-1:0] base, logic [COORD_BITS-1:0] w, h, stride);
      wait_idle();
      write_reg(CSR_FB_BASE, base);
      write_reg(CSR_FB_WIDTH, {32'($urandom), w});
      write_reg(CSR_FB_HEIGHT, {32'($urandom), h});
      write_reg(CSR_FB_STRIDE, {32'($urandom), stride});
      csr_we <= 1'b0;
      cfg_base = base;
      act_base = base;
      cfg_width = w;
      cfg_height = h;
      cfg_stride = stride;
   endtask

   function automatic req_type make_cmd(logic [1:0] k, logic [COORD_BITS-1:0] x, y, w, h,
                                        logic [ADDR_BITS-1:0] dst, src,
                                        logic [COORD_BITS-1:0] pitch);
      req_type r;
      r.opcode = OP_CMD;
      r.kind = k;
      r.rect_x = x;
      r.rect_y = y;
      r.rect_w = w;
      r.rect_h = h;
      r.fill_color = $urandom;
      r.dest_addr = dst;
      r.source_addr = src;
      r.pitch = pitch;
      return r;
   endfunction

   function automatic logic [COORD_BITS-1:0] pick_origin(logic [COORD_BITS-1:0] limit);
      case ($urandom_range(0, 9))
         0: return 16'($urandom);
         1: return limit;
         2, 3: return limit - 16'($urandom_range(1, 3));
         default: return (limit == 0) ? '0 : 16'($urandom_range(0, limit - 1));
      endcase
   endfunction

   // large extents only where clipping keeps the walk short
   function automatic logic [COORD_BITS-1:0] pick_extent(logic [COORD_BITS-1:0] limit,
                                                         logic [COORD_BITS-1:0] origin);
      if (origin >= limit) return 16'($urandom);
      if (limit - origin <= 12 && $urandom_range(0, 1) == 1) return 16'($urandom);
      return 16'($urandom_range(0, 6));
   endfunction

   function automatic req_type random_cmd(logic [1:0] k);
      req_type r;
      r = make_cmd(k, pick_origin(cfg_width), pick_origin(cfg_height), '0, '0,
                   ($urandom_range(0, 3) == 0) ? '0 : rand48(),
                   ($urandom_range(0, 15) == 0) ? '0 : rand48(), '0);
      r.rect_w = pick_extent(cfg_width, r.rect_x);
      r.rect_h = pick_extent(cfg_height, r.rect_y);
      case ($urandom_range(0, 7))
         0: r.pitch = '0;
         1: r.pitch = cfg_width - 16'd1;
         2: r.pitch = 16'($urandom);
         default: r.pitch = cfg_width + 16'($urandom_range(0, 8));
      endcase
      return r;
   endfunction

   // steps carry random junk in the fields they do not use
   function automatic req_type step_item();
      req_type r;
      r = random_cmd(2'($urandom));
      r.opcode = OP_STEP;
      return r;
   endfunction

   task automatic run_walk();
      while (walk_busy) send_item(step_item());
   endtask

   task automatic test_not_ready();
      send_item(make_cmd(KIND_FILL, 16'd0, 16'd0, 16'd1, 16'd1, 48'h100, '0, '0));
      send_item(step_item());
      set_fb(48'h100, 16'd8, 16'd4, 16'd7);
      send_item(make_cmd(KIND_FILL, 16'd0, 16'd0, 16'd1, 16'd1, 48'h100, '0, '0));
   endtask

   task automatic test_fill_blit();
      set_fb(48'h0000_1000_0000, 16'd16, 16'd8, 16'd32);
      // clipped to 2x2 at the corner, default base and stride
      send_item(make_cmd(KIND_FILL, 16'd14, 16'd6, 16'd5, 16'd5, '0, '0, '0));
      send_item(step_item());
      send_item(step_item());
      // busy wins over a bad kind
      send_item(make_cmd(KIND_BAD, 16'd0, 16'd0, 16'd1, 16'd1, '0, '0, '0));
      run_walk();
      send_item(make_cmd(KIND_BLIT, 16'd1, 16'd1, 16'd3, 16'd1, 48'h2000, 48'h8000_0000, 16'd20));
      run_walk();
   endtask

   task automatic test_flip_rejects();
      send_item(make_cmd(KIND_BAD, 16'd0, 16'd0, 16'd1, 16'd1, '0, '0, '0));
      send_item(make_cmd(KIND_FLIP, 16'd0, 16'd0, 16'd0, 16'd0, '0, '0, '0));
      send_item(make_cmd(KIND_FLIP, 16'd0, 16'd0, 16'd0, 16'd0, 48'hABC_0000, '0, '0));
      send_item(make_cmd(KIND_FILL, 16'd3, 16'd2, 16'd1, 16'd1, '0, '0, '0));
      run_walk();
      send_item(step_item());
   endtask

   task automatic test_silent_skips();
      send_item(make_cmd(KIND_FILL, 16'd16, 16'd0, 16'd4, 16'd4, '0, '0, '0));
      send_item(make_cmd(KIND_FILL, 16'd0, 16'd8, 16'd4, 16'd4, '0, '0, '0));
      send_item(make_cmd(KIND_FILL, 16'd0, 16'd0, 16'd0, 16'd4, '0, '0, '0));
      send_item(make_cmd(KIND_BLIT, 16'd0, 16'd0, 16'd2, 16'd2, '0, '0, 16'd20));
      send_item(make_cmd(KIND_BLIT, 16'd0, 16'd0, 16'd2, 16'd2, '0, 48'h5000, '0));
      send_item(make_cmd(KIND_FILL, 16'd0, 16'd0, 16'd2, 16'd2, '0, '0, 16'd15));
   endtask

   task automatic test_extremes();
      set_fb(48'hFFFF_FFFF_FFF0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_item(make_cmd(KIND_FILL, 16'hFFFE, 16'hFFFE, 16'hFFFF, 16'hFFFF, '0, '0, '0));
      run_walk();
      send_item(make_cmd(KIND_BLIT, 16'hFFFD, 16'hFFFE, 16'd2, 16'd1, 48'hFFFF_FFFF_FFFF,
                         48'hFFFF_FFFF_FFFF, 16'hFFFF));
      run_walk();
      set_fb(48'h1, 16'd1, 16'd1, 16'd1);
      send_item(make_cmd(KIND_FILL, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, '0, '0, '0));
      run_walk();
   endtask

   // receiver holds off while the sender keeps offering a whole walk
   task automatic test_backpressure();
      set_fb(rand48() | 48'h4, 16'd10, 16'd10, 16'd12);
      hold_req = 1'b1;
      send_item(make_cmd(KIND_FILL, 16'd0, 16'd0, 16'd6, 16'd6, '0, '0, '0));
      run_walk();
   endtask

   task automatic random_config();
      logic [ADDR_BITS-1:0]  base;
      logic [COORD_BITS-1:0] w, h;
      base = rand48();
      if (base == 0) base = 48'h4;
      if ($urandom_range(0, 3) == 0) base = ~48'($urandom_range(0, 4095));
      case ($urandom_range(0, 11))
         0: set_fb(base, 16'hFFFF, 16'hFFFF, 16'hFFFF);
         1: set_fb(base, 16'd1, 16'd1, 16'd1);
         2: begin
            case ($urandom_range(0, 3))
               0: set_fb('0, 16'd8, 16'd8, 16'd8);
               1: set_fb(base, 16'd0, 16'd8, 16'd8);
               2: set_fb(base, 16'd8, 16'd0, 16'd8);
               default: set_fb(base, 16'd9, 16'd8, 16'd8);
            endcase
         end
         default: begin
            w = 16'($urandom_range(1, 12));
            h = 16'($urandom_range(1, 12));
            set_fb(base, w, h, ($urandom_range(0, 5) == 0) ? 16'hFFFF
                                                           : w + 16'($urandom_range(0, 20)));
         end
      endcase
   endtask

   function automatic logic [1:0] walk_kind();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return KIND_FILL;
         9: return KIND_FLIP;
         default: return KIND_BLIT;
      endcase
   endfunction

   // mostly complete walks with random content, the rest loose items
   task automatic test_random();
      int stop_at, phase_end;
      stop_at = items_sent + 1550;
      while (items_sent < stop_at) begin
         random_config();
         phase_end = items_sent + $urandom_range(120, 240);
         while (items_sent < phase_end && items_sent < stop_at) begin
            if ($urandom_range(0, 9) < 7) begin
               send_item(random_cmd(walk_kind()));
               while (walk_busy) begin
                  if ($urandom_range(0, 19) == 0) send_item(random_cmd(2'($urandom)));
                  else send_item(step_item());
               end
            end else if ($urandom_range(0, 1) == 0) begin
               send_item(step_item());
            end else begin
               send_item(random_cmd(2'($urandom)));
            end
         end
         run_walk();
      end
   endtask

   initial begin
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_opcode      <= OP_CMD;
      req_kind        <= KIND_FILL;
      req_rect_x      <= '0;
      req_rect_y      <= '0;
      req_rect_w      <= '0;
      req_rect_h      <= '0;
      req_fill_color  <= '0;
      req_dest_addr   <= '0;
      req_source_addr <= '0;
      req_pitch       <= '0;
      csr_we          <= 1'b0;
      csr_index       <= CSR_FB_BASE;
      csr_wdata       <= '0;
      cfg_base = '0;
      cfg_width = '0;
      cfg_height = '0;
      cfg_stride = '0;
      act_base = '0;
      walk_busy = 1'b0;
      walk_copy = 1'b0;
      walk_col = '0;
      walk_row = '0;
      walk_w = '0;
      walk_h = '0;
      walk_x = '0;
      walk_y = '0;
      walk_color = '0;
      walk_dst = '0;
      walk_src = '0;
      walk_dpitch = '0;
      walk_spitch = '0;
      seq_next_num = 32'd1;
      seq_active = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_not_ready();
      test_fill_blit();
      test_flip_rejects();
      test_silent_skips();
      test_extremes();
      test_backpressure();
      test_random();

      wait_idle();
      repeat (4) @(posedge clock);
      if (access_q.size() != 0)
         report_mismatch("results missing", 64'(access_q.size()), 64'd0);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+src
src/crfb_pkg.sv
src/crfb_clip.sv
src/crfb_core.sv
src/clipped_rect_fill_blit_engine_top.sv
tb/tb.sv
